### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TCHI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define TCHI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### sv/tchi_pkg.sv
// ---------------------------------------------------------------------------
// tchi_pkg
// Types, sizes and codes shared by the terrain cell height interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package tchi_pkg;

   localparam int CELLS_PER_SIDE = 8;
   localparam int HEIGHT_BITS    = 24;
   localparam int GRID_STRIDE    = 2 * CELLS_PER_SIDE + 1;
   localparam int GRID_ENTRIES   = (CELLS_PER_SIDE + 1) * (CELLS_PER_SIDE + 1)
                                   + CELLS_PER_SIDE * CELLS_PER_SIDE;
   localparam int ADDR_BITS      = $clog2(GRID_ENTRIES);

   // Field widths of the ports
   localparam int INDEX_BITS = 8;
   localparam int CELL_BITS  = 3;
   localparam int FRAC_BITS  = 16;

   // Weights span roughly -2^16 .. 2^17
   localparam int WEIGHT_BITS = FRAC_BITS + 3;
   localparam int PROD_BITS   = WEIGHT_BITS + HEIGHT_BITS;
   localparam int ACC_BITS    = PROD_BITS + 2;
   localparam int Q_BITS      = ACC_BITS - FRAC_BITS;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_DRAIN,
      S_DONE
   } state_type;

   // Chosen triangle: centre weight first, then the two corners
   typedef struct packed {
      logic                          found;
      logic signed [WEIGHT_BITS-1:0] w_a;
      logic signed [WEIGHT_BITS-1:0] w_b;
      logic signed [WEIGHT_BITS-1:0] w_c;
      logic [ADDR_BITS-1:0]          addr_a;
      logic [ADDR_BITS-1:0]          addr_b;
      logic [ADDR_BITS-1:0]          addr_c;
   } tri_type;

   typedef struct packed {
      logic       clr;
      logic       rd;
      logic [1:0] sel;
   } mac_ctrl_type;

endpackage

`default_nettype wire

### sv/tchi_grid_ram.sv
// ---------------------------------------------------------------------------
// tchi_grid_ram
// Height grid store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tchi_grid_ram
   import tchi_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   we,
   input  wire logic [ADDR_BITS-1:0]   waddr,
   input  wire logic [HEIGHT_BITS-1:0] wdata,
   input  wire logic                   re,
   input  wire logic [ADDR_BITS-1:0]   raddr,
   output      logic [HEIGHT_BITS-1:0] rdata
);

   logic [HEIGHT_BITS-1:0] mem [GRID_ENTRIES];
   logic [HEIGHT_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### sv/tchi_tri_select.sv
// ---------------------------------------------------------------------------
// tchi_tri_select
// Picks the triangle of a cell that holds the point and gives its
// barycentric weights and the grid addresses of its three vertices.
// ---------------------------------------------------------------------------
`default_nettype none

module tchi_tri_select
   import tchi_pkg::*;
(
   input  wire logic [CELL_BITS-1:0] grid_row,
   input  wire logic [CELL_BITS-1:0] grid_col,
   input  wire logic [FRAC_BITS-1:0] frac_row,
   input  wire logic [FRAC_BITS-1:0] frac_col,
   output      tri_type              tri_sel
);

   localparam logic signed [WEIGHT_BITS-1:0] W_ONE = WEIGHT_BITS'(65536);
   localparam logic signed [WEIGHT_BITS-1:0] W_TOL = WEIGHT_BITS'(-7);

   logic signed [WEIGHT_BITS-1:0] x;
   logic signed [WEIGHT_BITS-1:0] y;
   logic signed [WEIGHT_BITS-1:0] nsum;
   logic signed [WEIGHT_BITS-1:0] psum;
   logic signed [WEIGHT_BITS-1:0] dxy;
   logic signed [WEIGHT_BITS-1:0] dyx;
   logic                          ok_n, ok_p, ok_xy, ok_yx, cell_ok;
   logic [ADDR_BITS-1:0]          base;
   logic [ADDR_BITS-1:0]          a_tl, a_tr, a_bl, a_br;

   always_comb begin
      x    = signed'(WEIGHT_BITS'(frac_row));
      y    = signed'(WEIGHT_BITS'(frac_col));
      nsum = W_ONE - x - y;
      psum = x + y - W_ONE;
      dxy  = x - y;
      dyx  = y - x;

      ok_n  = (nsum >= W_TOL);
      ok_p  = (psum >= W_TOL);
      ok_xy = (dxy >= W_TOL);
      ok_yx = (dyx >= W_TOL);

      cell_ok = (int'(grid_row) < CELLS_PER_SIDE) && (int'(grid_col) < CELLS_PER_SIDE);

      base = ADDR_BITS'(grid_row) * ADDR_BITS'(GRID_STRIDE) + ADDR_BITS'(grid_col);
      a_tl = base;
      a_tr = base + ADDR_BITS'(1);
      a_bl = base + ADDR_BITS'(GRID_STRIDE);
      a_br = base + ADDR_BITS'(GRID_STRIDE + 1);

      tri_sel.addr_a = base + ADDR_BITS'(CELLS_PER_SIDE + 1);
      tri_sel.found  = 1'b1;

      // Take the first triangle that holds the point, in the order left,
      // top, right, bottom
      if (ok_n && ok_xy) begin
         tri_sel.w_a    = y <<< 1;
         tri_sel.w_b    = nsum;
         tri_sel.w_c    = dxy;
         tri_sel.addr_b = a_tl;
         tri_sel.addr_c = a_bl;
      end else if (ok_yx && ok_n) begin
         tri_sel.w_a    = x <<< 1;
         tri_sel.w_b    = dyx;
         tri_sel.w_c    = nsum;
         tri_sel.addr_b = a_tr;
         tri_sel.addr_c = a_tl;
      end else if (ok_p && ok_yx) begin
         tri_sel.w_a    = (W_ONE - y) <<< 1;
         tri_sel.w_b    = psum;
         tri_sel.w_c    = dyx;
         tri_sel.addr_b = a_br;
         tri_sel.addr_c = a_tr;
      end else if (ok_xy && ok_p) begin
         tri_sel.w_a    = (W_ONE - x) <<< 1;
         tri_sel.w_b    = dxy;
         tri_sel.w_c    = psum;
         tri_sel.addr_b = a_bl;
         tri_sel.addr_c = a_br;
      end else begin
         tri_sel.found  = 1'b0;
         tri_sel.w_a    = '0;
         tri_sel.w_b    = '0;
         tri_sel.w_c    = '0;
         tri_sel.addr_b = a_tl;
         tri_sel.addr_c = a_tl;
      end

      if (!cell_ok) begin
         tri_sel.found = 1'b0;
      end
   end

endmodule

`default_nettype wire

### sv/tchi_mac.sv
// ---------------------------------------------------------------------------
// tchi_mac
// Multiply-accumulate of grid heights by their weights, with rounding to
// nearest and saturation to the height range.
// ---------------------------------------------------------------------------
`default_nettype none

module tchi_mac
   import tchi_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mac_ctrl_type           ctrl,
   input  wire tri_type                tri_sel,
   input  wire logic [HEIGHT_BITS-1:0] rd_data,
   output      logic [HEIGHT_BITS-1:0] height
);

   localparam logic signed [ACC_BITS-1:0] ROUND_BIAS = ACC_BITS'(32768);
   localparam logic signed [Q_BITS-1:0]   Q_MAX =
      Q_BITS'((64'sd1 <<< (HEIGHT_BITS - 1)) - 64'sd1);
   localparam logic signed [Q_BITS-1:0]   Q_MIN =
      Q_BITS'(-(64'sd1 <<< (HEIGHT_BITS - 1)));

   logic                          dv_ff, pv_ff;
   logic [1:0]                    sel_ff;
   logic signed [WEIGHT_BITS-1:0] weight;
   logic signed [PROD_BITS-1:0]   prod_in, prod_ff;
   logic signed [ACC_BITS-1:0]    acc_in, acc_ff;
   logic signed [Q_BITS-1:0]      q;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else begin
         dv_ff <= ctrl.rd;
         pv_ff <= dv_ff;
      end
   end

   // Track which vertex the returning read data belongs to
   always_ff @(posedge clock) begin
      sel_ff <= ctrl.sel;
   end

   always_comb begin
      case (sel_ff)
         2'd0:    weight = tri_sel.w_a;
         2'd1:    weight = tri_sel.w_b;
         2'd2:    weight = tri_sel.w_c;
         default: weight = '0;
      endcase
      prod_in = PROD_BITS'(signed'(rd_data) * weight);
   end

   always_ff @(posedge clock) begin
      if (dv_ff) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clr) begin
         acc_in = ROUND_BIAS;
      end else if (pv_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Arithmetic shift gives floor, so the bias rounds ties upwards
   always_comb begin
      q = acc_ff[ACC_BITS-1:FRAC_BITS];
      if (q > Q_MAX) begin
         height = Q_MAX[HEIGHT_BITS-1:0];
      end else if (q < Q_MIN) begin
         height = Q_MIN[HEIGHT_BITS-1:0];
      end else begin
         height = q[HEIGHT_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

### sv/terrain_cell_height_interp_top.sv
// ---------------------------------------------------------------------------
// terrain_cell_height_interp_top
// Height grid with barycentric height queries over four triangles a cell.
// ---------------------------------------------------------------------------
// A write item (func 0) loads one grid entry; indexes beyond the grid are
// dropped. A query (func 1) fetches the centre and the two corners of the
// chosen triangle one after another through the grid memory's single read
// port, then the multiply and accumulate pipeline drains and the result
// enters the output register. The input is taken again in the cycle after
// the result loads, so a new query is not taken before the last one is
// through. A query on a cell outside the grid returns height 0 with found
// low, without reading the grid. A result waits in the output register
// while the next item is taken; a query finishing while the previous
// result is still stalled holds until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module terrain_cell_height_interp_top
   import tchi_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic                   req_func,
   input  wire logic [INDEX_BITS-1:0]  req_entry_index,
   input  wire logic [HEIGHT_BITS-1:0] req_entry_height,
   input  wire logic [CELL_BITS-1:0]   req_grid_row,
   input  wire logic [CELL_BITS-1:0]   req_grid_col,
   input  wire logic [FRAC_BITS-1:0]   req_frac_row,
   input  wire logic [FRAC_BITS-1:0]   req_frac_col,

   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [HEIGHT_BITS-1:0] rsp_height,
   output      logic                   rsp_found
);

   state_type              state_ff, state_in;
   logic [1:0]             step_ff, step_in;
   tri_type                tri_comb, tri_ff;
   mac_ctrl_type           mac_ctrl;
   logic                   req_xfer, query_xfer, ram_we;
   logic                   out_free, out_load;
   logic [ADDR_BITS-1:0]   raddr;
   logic [HEIGHT_BITS-1:0] rd_data, mac_height;
   logic                   rsp_valid_ff;
   logic [HEIGHT_BITS-1:0] rsp_height_ff;
   logic                   rsp_found_ff;

   assign req_xfer   = req_valid && !req_stall;
   assign query_xfer = req_xfer && (req_func == FUNC_QUERY);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   tchi_tri_select u_tri (
      .grid_row (req_grid_row),
      .grid_col (req_grid_col),
      .frac_row (req_frac_row),
      .frac_col (req_frac_col),
      .tri_sel  (tri_comb)
   );

   always_ff @(posedge clock) begin
      if (query_xfer) begin
         tri_ff <= tri_comb;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (query_xfer) begin
               state_in = tri_comb.found ? S_READ : S_DONE;
            end
         end
         S_READ: begin
            if (step_ff == 2'd2) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (step_ff == 2'd1) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      step_in = (state_in != state_ff) ? 2'd0 : step_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Outputs of the sequencer
   always_comb begin
      req_stall    = (state_ff != S_IDLE);
      mac_ctrl.clr = query_xfer;
      mac_ctrl.rd  = (state_ff == S_READ);
      mac_ctrl.sel = step_ff;
      out_load     = (state_ff == S_DONE) && out_free;
      ram_we       = req_valid && (state_ff == S_IDLE) && (req_func == FUNC_WRITE)
                     && (int'(req_entry_index) < GRID_ENTRIES);
      case (step_ff)
         2'd0:    raddr = tri_ff.addr_a;
         2'd1:    raddr = tri_ff.addr_b;
         default: raddr = tri_ff.addr_c;
      endcase
   end

   tchi_grid_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_entry_index[ADDR_BITS-1:0]),
      .wdata (req_entry_height),
      .re    (mac_ctrl.rd),
      .raddr (raddr),
      .rdata (rd_data)
   );

   tchi_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .tri_sel (tri_ff),
      .rd_data (rd_data),
      .height  (mac_height)
   );

   // Output register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_height_ff <= tri_ff.found ? mac_height : '0;
         rsp_found_ff  <= tri_ff.found;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_height = rsp_height_ff;
   assign rsp_found  = rsp_found_ff;

endmodule

`default_nettype wire

### sv/tchi_checker.sv
// ---------------------------------------------------------------------------
// tchi_checker
// Port-level checks on the terrain cell height interpolator, bound to the
// top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tchi_checker
   import tchi_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic                   req_func,
   input  wire logic [INDEX_BITS-1:0]  req_entry_index,
   input  wire logic [HEIGHT_BITS-1:0] req_entry_height,
   input  wire logic [CELL_BITS-1:0]   req_grid_row,
   input  wire logic [CELL_BITS-1:0]   req_grid_col,
   input  wire logic [FRAC_BITS-1:0]   req_frac_row,
   input  wire logic [FRAC_BITS-1:0]   req_frac_col,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic [HEIGHT_BITS-1:0] rsp_height,
   input  wire logic                   rsp_found
);

   logic req_xfer;

   assign req_xfer = req_valid && !req_stall;

   // A stalled result holds
   `TCHI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_height) && $stable(rsp_found))

   // A miss carries a zero height
   `TCHI_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_found, rsp_height == '0)

   // A query keeps the input side busy in the following cycle
   `TCHI_ASSERT_NEXT(a_query_busy, clock, reset, req_xfer && (req_func == FUNC_QUERY), req_stall)

   // A write never makes a result appear
   `TCHI_ASSERT_NEXT(a_write_silent, clock, reset, !rsp_valid && req_xfer && (req_func == FUNC_WRITE), !rsp_valid)

endmodule

bind terrain_cell_height_interp_top tchi_checker u_tchi_checker (.*);

`default_nettype wire

### sim/terrain_cell_height_interp_top_tb.sv
// ---------------------------------------------------------------------------
// terrain_cell_height_interp_top_tb
// Self-checking bench for the terrain cell height interpolator.
// ---------------------------------------------------------------------------
// Grid writes and height queries go in through the request channel. A model
// of the grid in the bench predicts each query result not fixed in advance. A short
// directed table covers height extremes, the saturating corners of the
// triangle tolerance, the cell centre and writes beyond the grid. Random
// traffic follows. It only queries cells whose five entries have been
// loaded, and it leans on the triangle edges and on the frac extremes.
// Both channels idle at random. The receiver also holds off once for a long
// stretch, so that the block backs up.
// ---------------------------------------------------------------------------

module terrain_cell_height_interp_top_tb
   import tchi_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint W_ONE       = 65536;
   localparam longint W_TOL       = -7;
   localparam int     ITEM_TARGET = 1700;
   localparam int     HOLD_AT     = 400;
   localparam int     HOLD_CYCLES = 300;
   localparam int     DRAIN_WAIT  = 20;
   localparam int     CYCLE_LIMIT = 400000;

   localparam logic [HEIGHT_BITS-1:0] H_MAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
   localparam logic [HEIGHT_BITS-1:0] H_MIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
   localparam logic [HEIGHT_BITS-1:0] H_NEG_ONE = '1;

   typedef struct packed {
      logic                   func;
      logic [INDEX_BITS-1:0]  entry_index;
      logic [HEIGHT_BITS-1:0] entry_height;
      logic [CELL_BITS-1:0]   grid_row;
      logic [CELL_BITS-1:0]   grid_col;
      logic [FRAC_BITS-1:0]   frac_row;
      logic [FRAC_BITS-1:0]   frac_col;
      logic                   has_fixed;
      logic [HEIGHT_BITS-1:0] fixed_height;
      logic                   fixed_found;
   } grid_op_type;

   typedef struct packed {
      logic [HEIGHT_BITS-1:0] height;
      logic                   found;
   } height_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_func = FUNC_WRITE;
   logic [INDEX_BITS-1:0]  req_entry_index = '0;
   logic [HEIGHT_BITS-1:0] req_entry_height = '0;
   logic [CELL_BITS-1:0]   req_grid_row = '0;
   logic [CELL_BITS-1:0]   req_grid_col = '0;
   logic [FRAC_BITS-1:0]   req_frac_row = '0;
   logic [FRAC_BITS-1:0]   req_frac_col = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [HEIGHT_BITS-1:0] rsp_height;
   logic                   rsp_found;

   logic signed [HEIGHT_BITS-1:0] grid_model [GRID_ENTRIES];
   bit                            grid_loaded [GRID_ENTRIES];
   height_result_type             pending_heights [$];

   int mismatch_count = 0;
   int items_done     = 0;
   int cycle_count    = 0;
   int sender_calm    = 0;
   bit hold_request   = 1'b0;

   terrain_cell_height_interp_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_entry_index  (req_entry_index),
      .req_entry_height (req_entry_height),
      .req_grid_row     (req_grid_row),
      .req_grid_col     (req_grid_col),
      .req_frac_row     (req_frac_row),
      .req_frac_col     (req_frac_col),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_height       (rsp_height),
      .rsp_found        (rsp_found)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatch_count++;
   endtask

   // Barycentric height over the first triangle of the cell that holds the point
   function automatic height_result_type predict_height(
         input logic [CELL_BITS-1:0] row, input logic [CELL_BITS-1:0] col,
         input logic [FRAC_BITS-1:0] fr, input logic [FRAC_BITS-1:0] fc);
      height_result_type res;
      longint x, y, base, h, wc, acc, centre;
      longint tl, tr, bl, br;
      longint wa [4];
      longint wb [4];
      longint hb [4];
      longint hc [4];
      bit     hit;
      x   = fr;
      y   = fc;
      h   = 0;
      hit = 1'b0;
      if (row < CELLS_PER_SIDE && col < CELLS_PER_SIDE) begin
         base   = row * GRID_STRIDE + col;
         tl     = grid_model[base];
         tr     = grid_model[base + 1];
         bl     = grid_model[base + GRID_STRIDE];
         br     = grid_model[base + GRID_STRIDE + 1];
         centre = grid_model[base + CELLS_PER_SIDE + 1];
         wa = '{2 * y, 2 * x, 2 * (W_ONE - y), 2 * (W_ONE - x)};
         wb = '{W_ONE - x - y, y - x, x + y - W_ONE, x - y};
         hb = '{tl, tr, br, bl};
         hc = '{bl, tl, tr, br};
         for (int t = 0; t < 4 && !hit; t++) begin
            wc = W_ONE - wa[t] - wb[t];
            if (wa[t] >= W_TOL && wb[t] >= W_TOL && wc >= W_TOL) begin
               acc = wa[t] * centre + wb[t] * hb[t] + wc * hc[t] + 32768;
               h   = acc >>> 16;
               hit = 1'b1;
            end
         end
         if (h > longint'($signed(H_MAX)))
            h = $signed(H_MAX);
         if (h < longint'($signed(H_MIN)))
            h = $signed(H_MIN);
      end
      res.height = h[HEIGHT_BITS-1:0];
      res.found  = hit;
      return res;
   endfunction

   function automatic grid_op_type write_op(input int idx, input logic [HEIGHT_BITS-1:0] h);
      grid_op_type op;
      op              = '0;
      op.func         = FUNC_WRITE;
      op.entry_index  = idx[INDEX_BITS-1:0];
      op.entry_height = h;
      return op;
   endfunction

   function automatic grid_op_type query_op(input int row, input int col,
                                            input int fr, input int fc);
      grid_op_type op;
      op          = '0;
      op.func     = FUNC_QUERY;
      op.grid_row = row[CELL_BITS-1:0];
      op.grid_col = col[CELL_BITS-1:0];
      op.frac_row = fr[FRAC_BITS-1:0];
      op.frac_col = fc[FRAC_BITS-1:0];
      return op;
   endfunction

   function automatic grid_op_type fixed_query_op(input int row, input int col,
                                                  input int fr, input int fc,
                                                  input logic [HEIGHT_BITS-1:0] h);
      grid_op_type op;
      op              = query_op(row, col, fr, fc);
      op.has_fixed    = 1'b1;
      op.fixed_height = h;
      op.fixed_found  = 1'b1;
      return op;
   endfunction

   function automatic int pick_gap();
      int r;
      if (sender_calm > 0) begin
         sender_calm--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r == 0) begin
         sender_calm = $urandom_range(50, 150);
         return 0;
      end
      if (r < 140)
         return 0;
      if (r < 192)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [HEIGHT_BITS-1:0] pick_height();
      case ($urandom_range(0, 19))
         0:       return H_MAX;
         1:       return H_MIN;
         2:       return '0;
         3:       return H_NEG_ONE;
         default: return HEIGHT_BITS'($urandom());
      endcase
   endfunction

   function automatic int clamp_frac(input int v);
      if (v < 0)
         return 0;
      if (v > 65535)
         return 65535;
      return v;
   endfunction

   function automatic int frac_corner();
      case ($urandom_range(0, 4))
         0:       return 0;
         1:       return 1;
         2:       return 65534;
         3:       return 65535;
         default: return 32768;
      endcase
   endfunction

   task automatic send_item(input grid_op_type op);
      int gap;
      height_result_type want;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= op.func;
      req_entry_index  <= op.entry_index;
      req_entry_height <= op.entry_height;
      req_grid_row     <= op.grid_row;
      req_grid_col     <= op.grid_col;
      req_frac_row     <= op.frac_row;
      req_frac_col     <= op.frac_col;
      do @(posedge clock); while (req_stall);
      // Transfer taken at this edge
      if (op.func == FUNC_QUERY) begin
         if (op.has_fixed) begin
            want.height = op.fixed_height;
            want.found  = op.fixed_found;
         end else begin
            want = predict_height(op.grid_row, op.grid_col, op.frac_row, op.frac_col);
         end
         pending_heights.push_back(want);
         items_done++;
      end else if (op.entry_index < GRID_ENTRIES) begin
         grid_model[op.entry_index]  = op.entry_height;
         grid_loaded[op.entry_index] = 1'b1;
         items_done++;
      end
   endtask

   // Receiver: one long hold-off on request, otherwise random stretches
   initial begin : rsp_stall_gen
      int go_len;
      int stop_len;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         go_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 8);
         stop_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 3);
         rsp_stall <= 1'b0;
         repeat (go_len) @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (stop_len) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      height_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_heights.size() == 0) begin
            report_mismatch($sformatf("unexpected result height=%h found=%b",
                                      rsp_height, rsp_found));
         end else begin
            want = pending_heights.pop_front();
            if (rsp_height !== want.height)
               report_mismatch($sformatf("height %h, want %h",
                                         rsp_height, want.height));
            if (rsp_found !== want.found)
               report_mismatch($sformatf("found %b, want %b", rsp_found, want.found));
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("terrain_cell_height_interp_top test failed");
      $finish;
   end

   initial begin : stimulus
      grid_op_type directed_ops [$];
      grid_op_type op;
      int          base, missing, fx, fy;
      int          cell_entries [5];
      bit          hold_sent;

      hold_sent = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed_ops = {
         write_op(0, H_MAX), write_op(1, H_MIN), write_op(17, '0),
         write_op(18, HEIGHT_BITS'(1)), write_op(9, H_NEG_ONE),
         fixed_query_op(0, 0, 0, 0, H_MAX),
         fixed_query_op(0, 0, 32768, 32768, H_NEG_ONE),
         query_op(0, 0, 65535, 65535), query_op(0, 0, 65535, 0), query_op(0, 0, 0, 65535),
         // beyond the grid: must leave every entry alone
         write_op(145, HEIGHT_BITS'(12345)), write_op(255, H_NEG_ONE),
         query_op(0, 0, 65535, 1),
         write_op(126, H_MIN), write_op(127, H_MAX), write_op(143, H_MAX),
         write_op(144, H_MIN), write_op(135, H_MAX),
         // just past the T1 diagonal, inside tolerance: overshoots and clips
         fixed_query_op(7, 7, 32771, 32771, H_MAX),
         write_op(135, H_MIN), write_op(126, H_MAX),
         fixed_query_op(7, 7, 32771, 32771, H_MIN),
         query_op(7, 7, 0, 65535), query_op(7, 7, 65535, 65535), query_op(7, 7, 65535, 0)
      };
      foreach (directed_ops[i])
         send_item(directed_ops[i]);

      while (items_done < ITEM_TARGET) begin
         if (!hold_sent && items_done >= HOLD_AT) begin
            hold_request = 1'b1;
            hold_sent    = 1'b1;
         end
         op              = '0;
         op.entry_index  = INDEX_BITS'($urandom());
         op.entry_height = HEIGHT_BITS'($urandom());
         op.grid_row     = CELL_BITS'($urandom());
         op.grid_col     = CELL_BITS'($urandom());
         op.frac_row     = FRAC_BITS'($urandom());
         op.frac_col     = FRAC_BITS'($urandom());
         if ($urandom_range(0, 9) < 6) begin
            op.func = FUNC_QUERY;
            base = op.grid_row * GRID_STRIDE + op.grid_col;
            cell_entries = '{base, base + 1, base + GRID_STRIDE, base + GRID_STRIDE + 1,
                             base + CELLS_PER_SIDE + 1};
            missing = -1;
            foreach (cell_entries[k])
               if (missing < 0 && !grid_loaded[cell_entries[k]])
                  missing = cell_entries[k];
            if (missing >= 0) begin
               // load the missing entry first; the query comes later
               op.func         = FUNC_WRITE;
               op.entry_index  = missing[INDEX_BITS-1:0];
               op.entry_height = pick_height();
            end else begin
               fx = $urandom_range(0, 65535);
               case ($urandom_range(0, 4))
                  0: fy = $urandom_range(0, 65535);
                  1: fy = clamp_frac(65536 - fx + $urandom_range(0, 20) - 10);
                  2: fy = clamp_frac(fx + $urandom_range(0, 20) - 10);
                  3: begin
                     fx = 32768 + $urandom_range(0, 20) - 10;
                     fy = 32768 + $urandom_range(0, 20) - 10;
                  end
                  default: begin
                     fx = frac_corner();
                     fy = frac_corner();
                  end
               endcase
               op.frac_row = fx[FRAC_BITS-1:0];
               op.frac_col = fy[FRAC_BITS-1:0];
            end
         end else begin
            op.func         = FUNC_WRITE;
            op.entry_height = pick_height();
            op.entry_index  = INDEX_BITS'(($urandom_range(0, 19) == 0)
                                          ? $urandom_range(GRID_ENTRIES, 255)
                                          : $urandom_range(0, GRID_ENTRIES - 1));
         end
         send_item(op);
      end
      req_valid <= 1'b0;

      while (pending_heights.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("terrain_cell_height_interp_top test passed");
      else
         $display("terrain_cell_height_interp_top test failed");
      $finish;
   end

endmodule
